@@ rtl/rlpt_pkg.sv @@
// Shared types, constants and the 8x8 transpose for the raster to page transposer.
package rlpt_pkg;

   localparam int PAGE_ROWS   = 8;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int DIM_W       = 11;   // width/height registers
   localparam int ROW_W       = 10;
   localparam int COL_W       = 10;
   localparam int PAGE_W      = 7;
   localparam int MAX_DIM     = 1024;

   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_INVERT = 2'd2,
      REG_NONE   = 2'd3
   } csr_index_type;

   typedef logic [7:0][7:0] col_bytes_type;

   // one closed byte column waiting to be sent
   typedef struct packed {
      col_bytes_type          cols;
      logic [3:0]             count;
      logic [COL_W-1:0]       col_base;
      logic [PAGE_W-1:0]      page;
      logic                   ends_frame;
   } group_type;

   // column i takes bit (7-i) of every page row; page row n lands in bit n
   function automatic col_bytes_type transpose8(input logic [63:0] entry);
      col_bytes_type res;
      for (int i = 0; i < 8; i++) begin
         for (int n = 0; n < PAGE_ROWS; n++) begin
            res[i][n] = entry[8*n + 7 - i];
         end
      end
      return res;
   endfunction

endpackage

@@ rtl/raster_to_lcd_page_transpose.sv @@
// Top level: 1bpp raster bytes in, vertical page column bytes out.
//
// Raster bytes arrive top row first, left to right, with a row stride of
// ceil(width/32)*4 bytes (capped at the store depth); the MSB is the leftmost
// pixel and invert_pixels complements each byte on entry. Each byte column
// owns one 64-bit entry of a single-port-per-side page store (one byte lane
// per page row). Every beat is a read-modify-write of its entry: the read is
// issued when the beat is taken and the merged entry is written back from
// the merge stage; row 0 of a page rewrites the whole entry with the other
// lanes zero, so a short last page reads as zero. Successive beats always hit
// different entries (the stride is at least four), so no forwarding is
// needed. The byte in page row 7, or in the last row of the frame, closes its
// column: the merged entry is transposed 8x8 and handed to a column buffer,
// which sends up to eight column bytes, leftmost first, one per cycle while
// rsp_tready is high; columns at or beyond the width are dropped. Throughput:
// one raster byte per cycle for bytes that do not close a page, unless a
// closing byte ahead waits; a closing byte waits until the column buffer
// has drained the previous group, so closing rows are paced by it. The
// store needs no clearing pass after reset. A CSR write to width (0x0),
// height (0x4) or invert (0x8) restarts the frame at row 0, byte 0; a write
// to the spare address 0xc is ignored. Write only while the block is idle.
module raster_to_lcd_page_transpose #(
   parameter int MAX_STRIDE_BYTES = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   // raster byte input
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] pixel_byte
   // column byte output
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,   // [7:0] column_byte, [17:8] column_index,
                                                        // [24:18] page_index, [31:25] zero
   output logic                            rsp_tlast,   // last_in_group
   output logic                            rsp_tuser,   // frame_done
   // CSR port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rlpt_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rlpt_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rlpt_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import rlpt_pkg::*;

   localparam int STORE_DEPTH = (MAX_STRIDE_BYTES < 128) ? MAX_STRIDE_BYTES : 128;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int WIDTH_CAP   = (MAX_STRIDE_BYTES * 8 < MAX_DIM) ? MAX_STRIDE_BYTES * 8
                                                                 : MAX_DIM;

   // ---------------- CSRs ----------------
   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic             invert_ff, invert_in;
   logic             csr_wr;
   csr_index_type    csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_index_type'(csr_paddr[3:2]);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      invert_in = invert_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_WIDTH:  width_in  = csr_pwdata[DIM_W-1:0];
            REG_HEIGHT: height_in = csr_pwdata[DIM_W-1:0];
            REG_INVERT: invert_in = csr_pwdata[0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         REG_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         REG_INVERT: csr_prdata = CSR_DATA_W'(invert_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // ---------------- effective geometry ----------------
   logic [DIM_W-1:0]  w_eff, h_eff, w_lo, h_lo;
   logic [7:0]        stride_raw, stride_cap;
   logic [ADDR_W:0]   stride;

   always_comb begin
      w_lo  = (width_ff == '0) ? DIM_W'(1) : width_ff;
      w_eff = (w_lo > DIM_W'(WIDTH_CAP)) ? DIM_W'(WIDTH_CAP) : w_lo;
      h_lo  = (height_ff == '0) ? DIM_W'(1) : height_ff;
      h_eff = (h_lo > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : h_lo;
      stride_raw = 8'(((w_eff + DIM_W'(31)) >> 5) << 2);
      stride_cap = (stride_raw > 8'(STORE_DEPTH)) ? 8'(STORE_DEPTH) : stride_raw;
      stride     = (ADDR_W+1)'(stride_cap);
   end

   // ---------------- position counters, accept stage ----------------
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              req_acc;
   logic [2:0]        lane;
   logic              last_row, closing;
   logic [DIM_W-1:0]  col_base, col_rem;
   logic              has_cols;
   logic [3:0]        n_cols;
   logic [7:0]        pix;

   assign req_acc  = req_tvalid && req_tready;
   assign lane     = row_ff[2:0];
   assign last_row = (DIM_W'(row_ff) == (h_eff - DIM_W'(1)));
   assign closing  = (lane == 3'(PAGE_ROWS - 1)) || last_row;
   assign col_base = DIM_W'(pos_ff) << 3;
   assign col_rem  = w_eff - col_base;
   assign has_cols = (w_eff > col_base);
   assign n_cols   = !has_cols ? 4'd0 : ((col_rem >= DIM_W'(8)) ? 4'd8 : col_rem[3:0]);
   assign pix      = invert_ff ? ~req_tdata : req_tdata;

   always_comb begin
      pos_in = pos_ff;
      row_in = row_ff;
      if (csr_wr && (csr_idx != REG_NONE)) begin
         pos_in = '0;
         row_in = '0;
      end else if (req_acc) begin
         if (((ADDR_W+1)'(pos_ff) + (ADDR_W+1)'(1)) >= stride) begin
            pos_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            pos_in = pos_ff + ADDR_W'(1);
         end
      end
   end

   // ---------------- page store ----------------
   logic [63:0]       page_mem [STORE_DEPTH];
   logic [63:0]       rd_ff;
   logic [63:0]       merged;

   // ---------------- merge / write-back stage ----------------
   logic              s1_v_ff, s1_v_in;
   logic [7:0]        s1_byte_ff;
   logic [ADDR_W-1:0] s1_pos_ff;
   logic [2:0]        s1_lane_ff;
   logic              s1_emit_ff;
   logic [3:0]        s1_count_ff;
   logic [COL_W-1:0]  s1_base_ff;
   logic [PAGE_W-1:0] s1_page_ff;
   logic              s1_ends_ff;
   logic              s1_go;
   logic              emit_free;
   group_type         grp;

   assign s1_go      = s1_v_ff && (!s1_emit_ff || emit_free);
   assign req_tready = !s1_v_ff || s1_go;

   always_comb begin
      s1_v_in = s1_v_ff;
      if (req_acc) begin
         s1_v_in = 1'b1;
      end else if (s1_go) begin
         s1_v_in = 1'b0;
      end
   end

   // lane 0 starts a fresh page entry with the other rows cleared
   always_comb begin
      for (int k = 0; k < PAGE_ROWS; k++) begin
         if (3'(k) == s1_lane_ff) begin
            merged[8*k +: 8] = s1_byte_ff;
         end else if (s1_lane_ff == 3'd0) begin
            merged[8*k +: 8] = 8'd0;
         end else begin
            merged[8*k +: 8] = rd_ff[8*k +: 8];
         end
      end
   end

   always_comb begin
      grp.cols       = transpose8(merged);
      grp.count      = s1_count_ff;
      grp.col_base   = s1_base_ff;
      grp.page       = s1_page_ff;
      grp.ends_frame = s1_ends_ff;
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         rd_ff <= page_mem[pos_ff];
      end
      if (s1_go) begin
         page_mem[s1_pos_ff] <= merged;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_byte_ff  <= pix;
         s1_pos_ff   <= pos_ff;
         s1_lane_ff  <= lane;
         s1_emit_ff  <= closing && has_cols;
         s1_count_ff <= n_cols;
         s1_base_ff  <= col_base[COL_W-1:0];
         s1_page_ff  <= row_ff[ROW_W-1:3];
         s1_ends_ff  <= last_row && has_cols && (col_rem <= DIM_W'(8));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(128);
         height_ff <= DIM_W'(64);
         invert_ff <= 1'b0;
         pos_ff    <= '0;
         row_ff    <= '0;
         s1_v_ff   <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         invert_ff <= invert_in;
         pos_ff    <= pos_in;
         row_ff    <= row_in;
         s1_v_ff   <= s1_v_in;
      end
   end

   // ---------------- column byte output ----------------
   rlpt_col_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load_valid (s1_v_ff && s1_emit_ff),
      .load_group (grp),
      .load_free  (emit_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ rtl/rlpt_col_emit.sv @@
// Column byte buffer: holds one transposed group, sends one beat per cycle while ready.
module rlpt_col_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load_valid,
   input  rlpt_pkg::group_type  load_group,
   output logic                 load_free,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,   // [7:0] column_byte, [17:8] column_index,
                                             // [24:18] page_index, [31:25] zero
   output logic                 rsp_tlast,   // last_in_group
   output logic                 rsp_tuser    // frame_done
);
   import rlpt_pkg::*;

   group_type        grp_ff, grp_in;
   logic [2:0]       idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic             beat_acc, last_beat;
   logic [COL_W-1:0] col;

   assign beat_acc  = valid_ff && rsp_tready;
   assign last_beat = ((4'(idx_ff) + 4'd1) == grp_ff.count);
   assign load_free = !valid_ff || (beat_acc && last_beat);
   assign col       = grp_ff.col_base + COL_W'(idx_ff);

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'd0, grp_ff.page, col, grp_ff.cols[idx_ff]};
   assign rsp_tlast  = last_beat;
   assign rsp_tuser  = grp_ff.ends_frame && last_beat;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      grp_in   = grp_ff;
      if (load_valid && load_free) begin
         valid_in = 1'b1;
         idx_in   = 3'd0;
         grp_in   = load_group;
      end else if (beat_acc) begin
         if (last_beat) begin
            valid_in = 1'b0;
         end
         idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

endmodule

@@ rtl/rlpt_checker.sv @@
// Port-level checks for the raster to page transposer, bound to the top level.
module rlpt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [31:0]                     rsp_tdata,
   input logic                            rsp_tlast,
   input logic                            rsp_tuser
);

   // a stalled column beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("column beat changed while stalled");

   // the frame ends on the last beat of a group
   a_frame_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("frame_done outside last beat of group");

   // within a group the columns follow without gaps on the same page
   a_group_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_tdata[17:8] == $past(rsp_tdata[17:8]) + 10'd1)
         && (rsp_tdata[24:18] == $past(rsp_tdata[24:18])))
      else $error("column group broken");

   // nothing is offered straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("column beat offered after reset");

endmodule

bind raster_to_lcd_page_transpose rlpt_checker u_rlpt_checker (.*);
